// ----- sv/fixed_point_alu_top_macros.svh -----
// assertion macros for the fixed-point alu checker
// no dependencies; included by the checker file
`ifndef FIXED_POINT_ALU_TOP_MACROS_SVH
`define FIXED_POINT_ALU_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define FPA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: lbl failed");

// next-cycle implication, sampled on clk, quiet during reset
`define FPA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: lbl failed");

`endif

// ----- sv/fpa_pkg.sv -----
// shared types, constants and helper functions for the fixed-point alu
// no dependencies; used by every module of the block
package fpa_pkg;

	// word and fraction sizes (word size from 8 to 32 bits)
	localparam int W = 32;
	localparam int F = 8;
	localparam int OUT_W = 32;
	localparam int IN_W = 64;

	// dividend width and the restoring divider depth
	localparam int NB = W + F;
	// clamp width, big enough for a shifted integer and for a sum
	localparam int CW = W + F + 1;
	// unsigned quotient width, holds a rounded product or quotient
	localparam int QW = (2 * W + 1 > NB + 1) ? 2 * W + 1 : NB + 1;

	// latencies of the units, counted from the front end registers
	localparam int MUL_LAT = 3;
	localparam int DIV_LAT = NB + 2;
	// front end (two), divider, output register
	localparam int LAT = DIV_LAT + 3;

	localparam logic signed [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};
	localparam logic [W-1:0] MAXV_U = {1'b0, {(W - 1){1'b1}}};
	localparam logic [2*W:0] HALF = (F > 0) ? ((2 * W + 1)'(1) << ((F > 0) ? F - 1 : 0))
		: '0;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_GT = 4'd4,
		OP_LT = 4'd5,
		OP_GE = 4'd6,
		OP_LE = 4'd7,
		OP_EQ = 4'd8,
		OP_NE = 4'd9,
		OP_INC = 4'd10,
		OP_DEC = 4'd11,
		OP_MIN = 4'd12,
		OP_MAX = 4'd13,
		OP_TO_INT = 4'd14,
		OP_FROM_INT = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK = 2'd0,
		ERR_OVF = 2'd1,
		ERR_DIVZ = 2'd2
	} err_t;

	// one result word before packing
	typedef struct packed {
		logic [W-1:0] value;
		logic flag;
		err_t err;
	} res_t;

	// operand magnitudes and signs for the multiplier and divider
	typedef struct packed {
		logic [W-1:0] mag_a;
		logic [W-1:0] mag_b;
		logic neg;
		logic a_neg;
		logic b_zero;
	} opnd_t;

	// saturate a signed wide value to the word range
	function automatic res_t clamp_c(input logic signed [CW-1:0] x);
		res_t r;
		r.flag = 1'b0;
		r.err = ERR_OK;
		r.value = x[W-1:0];
		if (x > CW'(MAXV)) begin
			r.value = MAXV;
			r.err = ERR_OVF;
		end else if (x < CW'(MINV)) begin
			r.value = MINV;
			r.err = ERR_OVF;
		end
		return r;
	endfunction

	// apply a sign to a magnitude and saturate
	function automatic res_t sat_mag(input logic [QW-1:0] q, input logic neg);
		res_t r;
		logic [QW-1:0] nq;
		nq = ~q + QW'(1);
		r.flag = 1'b0;
		r.err = ERR_OK;
		r.value = neg ? nq[W-1:0] : q[W-1:0];
		if (!neg && q > QW'(MAXV_U)) begin
			r.value = MAXV;
			r.err = ERR_OVF;
		end else if (neg && q > QW'(MAXV_U) + QW'(1)) begin
			r.value = MINV;
			r.err = ERR_OVF;
		end
		return r;
	endfunction

endpackage

// ----- sv/fpa_front.sv -----
// front end: input register, simple operations and operand magnitudes
// depends on fpa_pkg
module fpa_front (
	input logic clk,
	input logic ce,
	input fpa_pkg::op_t op,
	input logic signed [fpa_pkg::W-1:0] operand_a,
	input logic signed [fpa_pkg::W-1:0] operand_b,
	output fpa_pkg::op_t op_s2,
	output fpa_pkg::res_t simple_s2,
	output fpa_pkg::opnd_t opnd_s2
);

	fpa_pkg::op_t op_s1;
	logic signed [fpa_pkg::W-1:0] a_s1;
	logic signed [fpa_pkg::W-1:0] b_s1;
	logic signed [fpa_pkg::W:0] sum;
	logic signed [fpa_pkg::W:0] diff;
	logic signed [fpa_pkg::CW-1:0] shl;
	fpa_pkg::res_t simple;
	fpa_pkg::opnd_t opnd;

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (ce) begin
			op_s1 <= op;
			a_s1 <= operand_a;
			b_s1 <= operand_b;
		end
	end

	// add, subtract, compare, increment, decrement, min, max and shift operations
	always_comb begin
		sum = (fpa_pkg::W + 1)'(a_s1) + (fpa_pkg::W + 1)'(b_s1);
		diff = (fpa_pkg::W + 1)'(a_s1) - (fpa_pkg::W + 1)'(b_s1);
		shl = fpa_pkg::CW'(a_s1) <<< fpa_pkg::F;
		simple.value = '0;
		simple.flag = 1'b0;
		simple.err = fpa_pkg::ERR_OK;
		case (op_s1)
			fpa_pkg::OP_ADD: simple = fpa_pkg::clamp_c(fpa_pkg::CW'(sum));
			fpa_pkg::OP_SUB: simple = fpa_pkg::clamp_c(fpa_pkg::CW'(diff));
			fpa_pkg::OP_GT: simple.flag = a_s1 > b_s1;
			fpa_pkg::OP_LT: simple.flag = a_s1 < b_s1;
			fpa_pkg::OP_GE: simple.flag = a_s1 >= b_s1;
			fpa_pkg::OP_LE: simple.flag = a_s1 <= b_s1;
			fpa_pkg::OP_EQ: simple.flag = a_s1 == b_s1;
			fpa_pkg::OP_NE: simple.flag = a_s1 != b_s1;
			fpa_pkg::OP_INC:
				simple = fpa_pkg::clamp_c(fpa_pkg::CW'(a_s1) + fpa_pkg::CW'(1));
			fpa_pkg::OP_DEC:
				simple = fpa_pkg::clamp_c(fpa_pkg::CW'(a_s1) - fpa_pkg::CW'(1));
			fpa_pkg::OP_MIN: simple.value = (a_s1 < b_s1) ? a_s1 : b_s1;
			fpa_pkg::OP_MAX: simple.value = (a_s1 > b_s1) ? a_s1 : b_s1;
			fpa_pkg::OP_TO_INT: simple.value = a_s1 >>> fpa_pkg::F;
			fpa_pkg::OP_FROM_INT: simple = fpa_pkg::clamp_c(shl);
			default: simple.value = '0;
		endcase
	end

	// magnitudes and signs for multiply and divide
	always_comb begin
		opnd.mag_a = a_s1[fpa_pkg::W-1] ? fpa_pkg::W'(-a_s1) : fpa_pkg::W'(a_s1);
		opnd.mag_b = b_s1[fpa_pkg::W-1] ? fpa_pkg::W'(-b_s1) : fpa_pkg::W'(b_s1);
		opnd.neg = a_s1[fpa_pkg::W-1] ^ b_s1[fpa_pkg::W-1];
		opnd.a_neg = a_s1[fpa_pkg::W-1];
		opnd.b_zero = (b_s1 == '0);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			op_s2 <= op_s1;
			simple_s2 <= simple;
			opnd_s2 <= opnd;
		end
	end

endmodule

// ----- sv/fpa_mul.sv -----
// three-stage multiplier: product, rounding, saturation
// depends on fpa_pkg
module fpa_mul (
	input logic clk,
	input logic ce,
	input fpa_pkg::opnd_t opnd,
	output fpa_pkg::res_t res_s3
);

	logic [2*fpa_pkg::W-1:0] prod_s1;
	logic neg_s1;
	logic [fpa_pkg::QW-1:0] q_s2;
	logic neg_s2;
	logic [2*fpa_pkg::W:0] rnd;

	// product of the magnitudes
	always_ff @(posedge clk) begin
		if (ce) begin
			prod_s1 <= opnd.mag_a * opnd.mag_b;
			neg_s1 <= opnd.neg;
		end
	end

	// round half away from zero on the magnitude
	assign rnd = (2 * fpa_pkg::W + 1)'(prod_s1) + fpa_pkg::HALF;

	always_ff @(posedge clk) begin
		if (ce) begin
			q_s2 <= fpa_pkg::QW'(rnd >> fpa_pkg::F);
			neg_s2 <= neg_s1;
		end
	end

	// sign and saturate
	always_ff @(posedge clk) begin
		if (ce) begin
			res_s3 <= fpa_pkg::sat_mag(q_s2, neg_s2);
		end
	end

endmodule

// ----- sv/fpa_div.sv -----
// pipelined restoring divider, one quotient bit per stage, then rounding
// depends on fpa_pkg
module fpa_div (
	input logic clk,
	input logic ce,
	input fpa_pkg::opnd_t opnd,
	output fpa_pkg::res_t res_q
);

	localparam int W = fpa_pkg::W;
	localparam int NB = fpa_pkg::NB;

	logic [W-1:0] rem_s [NB];
	logic [NB-1:0] num_s [NB];
	logic [NB-1:0] quo_s [NB];
	logic [W-1:0] den_s [NB];
	logic neg_s [NB];
	logic aneg_s [NB];
	logic bz_s [NB];

	logic [fpa_pkg::QW-1:0] qr_q;
	logic neg_q;
	logic aneg_q;
	logic bz_q;
	logic rnd;

	// one restoring step per stage
	for (genvar k = 0; k < NB; k++) begin : g_step
		logic [W-1:0] rem_in;
		logic [NB-1:0] num_in;
		logic [NB-1:0] quo_in;
		logic [W-1:0] den_in;
		logic neg_in;
		logic aneg_in;
		logic bz_in;
		logic [W+1:0] trial;
		logic [W:0] part;
		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = NB'(opnd.mag_a) << fpa_pkg::F;
			assign quo_in = '0;
			assign den_in = opnd.mag_b;
			assign neg_in = opnd.neg;
			assign aneg_in = opnd.a_neg;
			assign bz_in = opnd.b_zero;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign num_in = num_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
			assign neg_in = neg_s[k-1];
			assign aneg_in = aneg_s[k-1];
			assign bz_in = bz_s[k-1];
		end
		assign part = {rem_in, num_in[NB-1]};
		assign trial = (W + 2)'(part) - (W + 2)'(den_in);
		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k] <= trial[W+1] ? part[W-1:0] : trial[W-1:0];
				num_s[k] <= num_in << 1;
				quo_s[k] <= {quo_in[NB-2:0], ~trial[W+1]};
				den_s[k] <= den_in;
				neg_s[k] <= neg_in;
				aneg_s[k] <= aneg_in;
				bz_s[k] <= bz_in;
			end
		end
	end

	// round up when twice the remainder reaches the divisor
	assign rnd = ({1'b0, rem_s[NB-1], 1'b0} >= {2'b00, den_s[NB-1]});

	always_ff @(posedge clk) begin
		if (ce) begin
			qr_q <= fpa_pkg::QW'(quo_s[NB-1]) + fpa_pkg::QW'(rnd);
			neg_q <= neg_s[NB-1];
			aneg_q <= aneg_s[NB-1];
			bz_q <= bz_s[NB-1];
		end
	end

	// sign, saturate, divide by zero override
	always_ff @(posedge clk) begin
		if (ce) begin
			if (bz_q) begin
				res_q.value <= aneg_q ? fpa_pkg::MINV : fpa_pkg::MAXV;
				res_q.flag <= 1'b0;
				res_q.err <= fpa_pkg::ERR_DIVZ;
			end else begin
				res_q <= fpa_pkg::sat_mag(qr_q, neg_q);
			end
		end
	end

endmodule

// ----- sv/fixed_point_alu_top.sv -----
// Signed fixed-point ALU (Q24.8 by default) on a stream interface. One word
// is taken every clock cycle while the output is not stalled, and each word
// gives exactly one result word, in order. The latency is set by the
// restoring divider, which resolves one quotient bit per stage; every
// operation shares that latency. The whole pipeline halts while the output
// word waits, so nothing is lost or repeated.
// depends on fpa_pkg, fpa_front, fpa_mul, fpa_div
module fixed_point_alu_top (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// operand_a [31:0], operand_b [63:32]
	input logic [fpa_pkg::IN_W-1:0] s_axis_tdata,
	// operation [3:0]
	input logic [3:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// result_value [31:0]
	output logic [fpa_pkg::OUT_W-1:0] m_axis_tdata,
	// compare_flag [0], error_code [2:1]
	output logic [2:0] m_axis_tuser
);

	localparam int SD = fpa_pkg::DIV_LAT;
	localparam int MD = fpa_pkg::DIV_LAT - fpa_pkg::MUL_LAT;

	logic ce;
	logic [fpa_pkg::LAT-1:0] vld_q;
	fpa_pkg::op_t op_s2;
	fpa_pkg::res_t simple_s2;
	fpa_pkg::opnd_t opnd_s2;
	fpa_pkg::res_t mul_res;
	fpa_pkg::res_t div_res;
	fpa_pkg::res_t sdel_q [SD];
	fpa_pkg::op_t odel_q [SD];
	fpa_pkg::res_t mdel_q [MD];
	fpa_pkg::res_t out_q;

	// the pipeline moves whenever the output register can take a word
	assign ce = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[fpa_pkg::LAT-2:0], s_axis_tvalid};
		end
	end

	fpa_front u_front (
		.clk(clk),
		.ce(ce),
		.op(fpa_pkg::op_t'(s_axis_tuser)),
		.operand_a($signed(s_axis_tdata[fpa_pkg::W-1:0])),
		.operand_b($signed(s_axis_tdata[32+fpa_pkg::W-1:32])),
		.op_s2(op_s2),
		.simple_s2(simple_s2),
		.opnd_s2(opnd_s2)
	);

	fpa_mul u_mul (
		.clk(clk),
		.ce(ce),
		.opnd(opnd_s2),
		.res_s3(mul_res)
	);

	fpa_div u_div (
		.clk(clk),
		.ce(ce),
		.opnd(opnd_s2),
		.res_q(div_res)
	);

	// align the simple results and the opcode with the divider
	always_ff @(posedge clk) begin
		if (ce) begin
			sdel_q[0] <= simple_s2;
			odel_q[0] <= op_s2;
			for (int i = 1; i < SD; i++) begin
				sdel_q[i] <= sdel_q[i-1];
				odel_q[i] <= odel_q[i-1];
			end
		end
	end

	// align the multiplier with the divider
	always_ff @(posedge clk) begin
		if (ce) begin
			mdel_q[0] <= mul_res;
			for (int i = 1; i < MD; i++) begin
				mdel_q[i] <= mdel_q[i-1];
			end
		end
	end

	// output register picks the unit that owns the opcode
	always_ff @(posedge clk) begin
		if (ce) begin
			case (odel_q[SD-1])
				fpa_pkg::OP_MUL: out_q <= mdel_q[MD-1];
				fpa_pkg::OP_DIV: out_q <= div_res;
				default: out_q <= sdel_q[SD-1];
			endcase
		end
	end

	assign m_axis_tvalid = vld_q[fpa_pkg::LAT-1];
	assign m_axis_tdata = fpa_pkg::OUT_W'($signed(out_q.value));
	assign m_axis_tuser = {out_q.err, out_q.flag};

endmodule

// ----- sv/fpa_checker.sv -----
// port-level checker for the fixed-point alu, bound to the top level
// depends on fpa_pkg and fixed_point_alu_top_macros.svh
`include "fixed_point_alu_top_macros.svh"

module fpa_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [fpa_pkg::IN_W-1:0] s_axis_tdata,
	input logic [3:0] s_axis_tuser,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [fpa_pkg::OUT_W-1:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser
);

	// a stalled output word stays offered
	`FPA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	// error codes stay within their meaning
	`FPA_ASSERT_NOW(a_err_code, m_axis_tvalid, m_axis_tuser[2:1] != 2'd3)

	// a true comparison carries a zero value and no error
	`FPA_ASSERT_NOW(a_cmp_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0 && m_axis_tuser[2:1] == 2'd0)

	// divide by zero always gives a saturated value
	`FPA_ASSERT_NOW(a_divz_sat, m_axis_tvalid && m_axis_tuser[2:1] == 2'd2, m_axis_tdata == fpa_pkg::OUT_W'(fpa_pkg::MAXV) || m_axis_tdata == fpa_pkg::OUT_W'(fpa_pkg::MINV))

endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (.*);
